@@ rtl/core/gcwp_pkg.sv @@
// gcwp_pkg: shared types, command codes and constants of the GPU command word parser
// no dependencies; used by gcwp_result_fifo and gpu_command_word_parser_core

package gcwp_pkg;

    // vram geometry defaults and fixed address width
    localparam int VRAM_WIDTH_DEF  = 1024;
    localparam int VRAM_HEIGHT_DEF = 512;
    localparam int ADDR_W          = 19;

    // result queue depth, a power of two
    localparam int FIFO_DEPTH = 4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CONSUMED = 2'd0,
        KIND_PRIM     = 2'd1,
        KIND_PIXEL    = 2'd2,
        KIND_UNKNOWN  = 2'd3
    } kind_t;

    // primitive type codes
    localparam logic [2:0] PRIM_MONO_QUAD   = 3'd0;
    localparam logic [2:0] PRIM_TEX_QUAD    = 3'd1;
    localparam logic [2:0] PRIM_SHADED_TRI  = 3'd2;
    localparam logic [2:0] PRIM_SHADED_QUAD = 3'd3;
    localparam logic [2:0] PRIM_RECT16      = 3'd4;

    // command bytes
    localparam logic [7:0] CMD_NOP            = 8'h00;
    localparam logic [7:0] CMD_NOP_ALT        = 8'h01;
    localparam logic [7:0] CMD_MONO_QUAD      = 8'h28;
    localparam logic [7:0] CMD_TEX_QUAD       = 8'h2C;
    localparam logic [7:0] CMD_SHADED_TRI     = 8'h30;
    localparam logic [7:0] CMD_SHADED_QUAD    = 8'h38;
    localparam logic [7:0] CMD_RECT16         = 8'h78;
    localparam logic [7:0] CMD_FILL_PIXEL     = 8'h68;
    localparam logic [7:0] CMD_COPY_TO_VRAM   = 8'hA0;
    localparam logic [7:0] CMD_COPY_FROM_VRAM = 8'hC0;
    localparam logic [7:0] CMD_TEX_PAGE       = 8'hE1;
    localparam logic [7:0] CMD_TEX_WINDOW     = 8'hE2;
    localparam logic [7:0] CMD_AREA_TL        = 8'hE3;
    localparam logic [7:0] CMD_AREA_BR        = 8'hE4;
    localparam logic [7:0] CMD_DRAW_OFFSET    = 8'hE5;
    localparam logic [7:0] CMD_MASK_BITS      = 8'hE6;

    // one result as presented on the output channel
    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  vram_address;
        logic [15:0]        vram_pixel;
        logic [2:0]         prim_type;
        logic [3:0]         word_index;
        logic [31:0]        prim_word;
        logic               last;
        logic               busy_res;
        logic [9:0]         area_left;
        logic [8:0]         area_top;
        logic [9:0]         area_right;
        logic [8:0]         area_bottom;
    } res_t;

    // result queue controls
    typedef struct packed {
        logic push_first;
        logic push_second;
        logic pop;
    } fifo_ctl_t;

    // index of the final word of each drawing packet
    function automatic logic [3:0] prim_final_index(input logic [2:0] ptype);
        logic [3:0] idx;
        begin
            case (ptype)
                PRIM_MONO_QUAD:   idx = 4'd4;
                PRIM_TEX_QUAD:    idx = 4'd8;
                PRIM_SHADED_TRI:  idx = 4'd5;
                PRIM_SHADED_QUAD: idx = 4'd7;
                PRIM_RECT16:      idx = 4'd1;
                default:          idx = 4'd1;
            endcase
            return idx;
        end
    endfunction

endpackage

@@ rtl/core/gcwp_result_fifo.sv @@
// gcwp_result_fifo: small result queue, up to two pushes and one pop per cycle
// depends on gcwp_pkg (res_t, fifo_ctl_t, FIFO_DEPTH)

module gcwp_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcwp_pkg::fifo_ctl_t  ctl,
    input  gcwp_pkg::res_t       data_first,
    input  gcwp_pkg::res_t       data_second,
    output gcwp_pkg::res_t       head,
    output logic [$clog2(gcwp_pkg::FIFO_DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(gcwp_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(gcwp_pkg::FIFO_DEPTH+1);

    gcwp_pkg::res_t     mem_reg [gcwp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wp_inc;

    // pointer and fill count update
    always_comb
    begin
        wp_inc  = wp_reg + PTR_W'(1);
        wp_next = wp_reg;
        if (ctl.push_second)
        begin
            wp_next = wp_reg + PTR_W'(2);
        end
        else if (ctl.push_first)
        begin
            wp_next = wp_inc;
        end
        rp_next    = ctl.pop ? rp_reg + PTR_W'(1) : rp_reg;
        count_next = count_reg + CNT_W'(ctl.push_first) + CNT_W'(ctl.push_second)
                     - CNT_W'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (ctl.push_first)
        begin
            mem_reg[wp_reg] <= data_first;
        end
        if (ctl.push_second)
        begin
            mem_reg[wp_inc] <= data_second;
        end
    end

    assign head  = mem_reg[rp_reg];
    assign count = count_reg;

endmodule

@@ rtl/core/gpu_command_word_parser_core.sv @@
// gpu_command_word_parser_core: decodes GPU command words into primitive words and
// vram pixel writes; depends on gcwp_pkg and gcwp_result_fifo
// an accepted word is registered in the result stage, then pushed into the result queue
// throughput: 1 word per cycle unless in_stall; a word with two pixel results pops singly,
// so a long run of copy data words goes at the output rate of one result per cycle
// reset: rst_n clears the parser to idle, drawing area to zero and the result queue

module gpu_command_word_parser_core #(
    parameter int VRAM_WIDTH  = gcwp_pkg::VRAM_WIDTH_DEF,
    parameter int VRAM_HEIGHT = gcwp_pkg::VRAM_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [18:0] vram_address,
    output logic [15:0] vram_pixel,
    output logic [2:0]  prim_type,
    output logic [3:0]  word_index,
    output logic [31:0] prim_word,
    output logic        last,
    output logic        busy_res,
    output logic [9:0]  area_left,
    output logic [8:0]  area_top,
    output logic [9:0]  area_right,
    output logic [8:0]  area_bottom
);

    localparam int XW      = $clog2(VRAM_WIDTH);
    localparam int YW      = $clog2(VRAM_HEIGHT);
    localparam int X_STEPS = 17 - $clog2(VRAM_WIDTH + 1);
    localparam int Y_STEPS = 17 - $clog2(VRAM_HEIGHT + 1);
    localparam int SUM_W   = (XW + YW > gcwp_pkg::ADDR_W) ? XW + YW : gcwp_pkg::ADDR_W;
    localparam int CNT_W   = $clog2(gcwp_pkg::FIFO_DEPTH + 1);

    // packet positions
    localparam logic [3:0] POS_FIRST       = 4'd1;
    localparam logic [3:0] POS_COPY_SIZE   = 4'd2;
    localparam logic [3:0] POS_COPY_DATA   = 4'd3;
    localparam logic [3:0] POS_READBACK_END = 4'd2;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_PRIM     = 5'b00010,
        MODE_COPY     = 5'b00100,
        MODE_PIXEL    = 5'b01000,
        MODE_READBACK = 5'b10000
    } mode_t;

    // one result before address generation
    typedef struct packed {
        gcwp_pkg::kind_t kind;
        logic [XW-1:0]   x;
        logic [YW-1:0]   y;
        logic [15:0]     pixel;
        logic [2:0]      ptype;
        logic [3:0]      idx;
        logic [31:0]     pword;
        logic            last;
    } slot_t;

    // copy walk position
    typedef struct packed {
        logic [15:0]   col;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
    } walk_t;

    // control state
    mode_t          mode_reg, mode_next;
    logic [2:0]     ptype_reg, ptype_next;
    logic [3:0]     pos_reg, pos_next;
    logic [30:0]    words_left_reg, words_left_next;
    logic [18:0]    corner_tl_reg, corner_tl_next;
    logic [18:0]    corner_br_reg, corner_br_next;
    logic           s_valid_reg, s_valid_next;

    // copy and pixel payload state
    logic           odd_reg, odd_next;
    logic [15:0]    width_reg, width_next;
    logic [XW-1:0]  ox_reg, ox_next;
    logic [YW-1:0]  oy_reg, oy_next;
    walk_t          walk_reg, walk_next;
    logic [15:0]    pixel_reg, pixel_next;

    // stage holding one item's results
    slot_t          s_first_reg, s_first_next;
    slot_t          s_second_reg, s_second_next;
    logic           s_two_reg, s_two_next;
    logic           s_busy_reg, s_busy_next;
    logic [18:0]    s_tl_reg, s_tl_next;
    logic [18:0]    s_br_reg, s_br_next;

    logic           accept;
    logic           fifo_room;
    logic           drain;
    logic [CNT_W-1:0] fifo_count;
    gcwp_pkg::fifo_ctl_t fifo_ctl;
    gcwp_pkg::res_t res_first, res_second, head;

    // decode scratch
    mode_t          mode_cur;
    logic [3:0]     pos_cur;
    logic [7:0]     cmd;
    logic [31:0]    size_prod;
    logic [32:0]    size_sum;
    logic           final_word;
    walk_t          walk_mid;

    // value modulo the vram width by shifted compare and subtract
    function automatic logic [XW-1:0] wrap_x(input logic [15:0] v);
        logic [16:0] r;
        begin
            r = {1'b0, v};
            for (int k = X_STEPS - 1; k >= 0; k--)
            begin
                if (r >= (17'(VRAM_WIDTH) << k))
                begin
                    r = r - (17'(VRAM_WIDTH) << k);
                end
            end
            return r[XW-1:0];
        end
    endfunction

    // value modulo the vram height
    function automatic logic [YW-1:0] wrap_y(input logic [15:0] v);
        logic [16:0] r;
        begin
            r = {1'b0, v};
            for (int k = Y_STEPS - 1; k >= 0; k--)
            begin
                if (r >= (17'(VRAM_HEIGHT) << k))
                begin
                    r = r - (17'(VRAM_HEIGHT) << k);
                end
            end
            return r[YW-1:0];
        end
    endfunction

    // step the copy walk by one pixel
    function automatic walk_t walk_step(input walk_t p, input logic [15:0] w,
                                        input logic [XW-1:0] ox);
        walk_t      n;
        logic [16:0] c1;
        begin
            c1 = {1'b0, p.col} + 17'd1;
            if (c1 >= {1'b0, w})
            begin
                n.col = '0;
                n.x   = ox;
                n.y   = (p.y == YW'(VRAM_HEIGHT - 1)) ? '0 : p.y + YW'(1);
            end
            else
            begin
                n.col = c1[15:0];
                n.x   = (p.x == XW'(VRAM_WIDTH - 1)) ? '0 : p.x + XW'(1);
                n.y   = p.y;
            end
            return n;
        end
    endfunction

    // result with its vram address
    function automatic gcwp_pkg::res_t make_res(input slot_t s, input logic busy,
                                                input logic [18:0] tl,
                                                input logic [18:0] br);
        gcwp_pkg::res_t r;
        logic [SUM_W-1:0] full;
        begin
            full = SUM_W'(s.y) * SUM_W'(VRAM_WIDTH) + SUM_W'(s.x);
            r.kind         = s.kind;
            r.vram_address = full[gcwp_pkg::ADDR_W-1:0];
            r.vram_pixel   = s.pixel;
            r.prim_type    = s.ptype;
            r.word_index   = s.idx;
            r.prim_word    = s.pword;
            r.last         = s.last;
            r.busy_res     = busy;
            r.area_left    = tl[9:0];
            r.area_top     = tl[18:10];
            r.area_right   = br[9:0];
            r.area_bottom  = br[18:10];
            return r;
        end
    endfunction

    // handshake: the stage drains when the queue has room for two results
    assign fifo_room = fifo_count <= CNT_W'(gcwp_pkg::FIFO_DEPTH - 2);
    assign drain     = s_valid_reg && fifo_room;
    assign in_stall  = s_valid_reg && !fifo_room;
    assign accept    = in_valid && !in_stall;

    // word decode and state update
    always_comb
    begin
        mode_cur   = action ? MODE_IDLE : mode_reg;
        pos_cur    = action ? '0 : pos_reg;
        cmd        = word[31:24];
        size_prod  = {16'b0, word[15:0]} * {16'b0, word[31:16]};
        size_sum   = {1'b0, size_prod} + 33'd1;
        final_word = words_left_reg <= 31'd1;
        walk_mid   = walk_step(walk_reg, width_reg, ox_reg);

        mode_next       = mode_cur;
        ptype_next      = ptype_reg;
        pos_next        = pos_cur;
        words_left_next = action ? '0 : words_left_reg;
        corner_tl_next  = corner_tl_reg;
        corner_br_next  = corner_br_reg;
        odd_next        = odd_reg;
        width_next      = width_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        walk_next       = walk_reg;
        pixel_next      = pixel_reg;

        s_first_next      = '0;
        s_first_next.kind = gcwp_pkg::KIND_CONSUMED;
        s_first_next.last = 1'b1;
        s_second_next     = '0;
        s_two_next        = 1'b0;

        case (mode_cur)
            MODE_IDLE:
            begin
                case (cmd)
                    gcwp_pkg::CMD_NOP, gcwp_pkg::CMD_NOP_ALT:
                    begin
                        mode_next = MODE_IDLE;
                    end
                    gcwp_pkg::CMD_MONO_QUAD, gcwp_pkg::CMD_TEX_QUAD,
                    gcwp_pkg::CMD_SHADED_TRI, gcwp_pkg::CMD_SHADED_QUAD,
                    gcwp_pkg::CMD_RECT16:
                    begin
                        case (cmd)
                            gcwp_pkg::CMD_MONO_QUAD:   ptype_next = gcwp_pkg::PRIM_MONO_QUAD;
                            gcwp_pkg::CMD_TEX_QUAD:    ptype_next = gcwp_pkg::PRIM_TEX_QUAD;
                            gcwp_pkg::CMD_SHADED_TRI:  ptype_next = gcwp_pkg::PRIM_SHADED_TRI;
                            gcwp_pkg::CMD_SHADED_QUAD: ptype_next = gcwp_pkg::PRIM_SHADED_QUAD;
                            default:                   ptype_next = gcwp_pkg::PRIM_RECT16;
                        endcase
                        mode_next          = MODE_PRIM;
                        pos_next           = POS_FIRST;
                        s_first_next.kind  = gcwp_pkg::KIND_PRIM;
                        s_first_next.ptype = ptype_next;
                        s_first_next.pword = word;
                        s_first_next.last  = 1'b0;
                    end
                    gcwp_pkg::CMD_COPY_TO_VRAM:
                    begin
                        mode_next = MODE_COPY;
                        pos_next  = POS_FIRST;
                    end
                    gcwp_pkg::CMD_COPY_FROM_VRAM:
                    begin
                        mode_next = MODE_READBACK;
                        pos_next  = POS_FIRST;
                    end
                    gcwp_pkg::CMD_FILL_PIXEL:
                    begin
                        pixel_next = {1'b0, word[23:19], word[15:11], word[7:3]};
                        mode_next  = MODE_PIXEL;
                        pos_next   = POS_FIRST;
                    end
                    // texture page, window, offset and mask have no consumer here
                    gcwp_pkg::CMD_TEX_PAGE, gcwp_pkg::CMD_TEX_WINDOW,
                    gcwp_pkg::CMD_DRAW_OFFSET, gcwp_pkg::CMD_MASK_BITS:
                    begin
                        mode_next = MODE_IDLE;
                    end
                    gcwp_pkg::CMD_AREA_TL:
                    begin
                        corner_tl_next = word[18:0];
                    end
                    gcwp_pkg::CMD_AREA_BR:
                    begin
                        corner_br_next = word[18:0];
                    end
                    default:
                    begin
                        s_first_next.kind = gcwp_pkg::KIND_UNKNOWN;
                    end
                endcase
            end

            MODE_PRIM:
            begin
                s_first_next.kind  = gcwp_pkg::KIND_PRIM;
                s_first_next.ptype = ptype_reg;
                s_first_next.idx   = pos_cur;
                s_first_next.pword = word;
                if (pos_cur >= gcwp_pkg::prim_final_index(ptype_reg))
                begin
                    s_first_next.last = 1'b1;
                    mode_next         = MODE_IDLE;
                    pos_next          = '0;
                    words_left_next   = '0;
                end
                else
                begin
                    s_first_next.last = 1'b0;
                    pos_next          = pos_cur + 4'd1;
                end
            end

            MODE_COPY:
            begin
                if (pos_cur == POS_FIRST)
                begin
                    ox_next  = wrap_x(word[15:0]);
                    oy_next  = wrap_y(word[31:16]);
                    pos_next = POS_COPY_SIZE;
                end
                else if (pos_cur == POS_COPY_SIZE)
                begin
                    width_next      = word[15:0];
                    odd_next        = word[0] & word[16];
                    walk_next.col   = '0;
                    walk_next.x     = ox_reg;
                    walk_next.y     = oy_reg;
                    words_left_next = size_sum[31:1];
                    if (size_prod == 32'd0)
                    begin
                        mode_next = MODE_IDLE;
                        pos_next  = '0;
                    end
                    else
                    begin
                        pos_next = POS_COPY_DATA;
                    end
                end
                else
                begin
                    // data word: low half first, high half unless the odd tail pixel
                    s_first_next.kind  = gcwp_pkg::KIND_PIXEL;
                    s_first_next.x     = walk_reg.x;
                    s_first_next.y     = walk_reg.y;
                    s_first_next.pixel = word[15:0];
                    if (final_word && odd_reg)
                    begin
                        s_first_next.last = 1'b1;
                        walk_next         = walk_mid;
                    end
                    else
                    begin
                        s_first_next.last   = 1'b0;
                        s_second_next.kind  = gcwp_pkg::KIND_PIXEL;
                        s_second_next.x     = walk_mid.x;
                        s_second_next.y     = walk_mid.y;
                        s_second_next.pixel = word[31:16];
                        s_second_next.last  = 1'b1;
                        s_two_next          = 1'b1;
                        walk_next           = walk_step(walk_mid, width_reg, ox_reg);
                    end
                    if (final_word)
                    begin
                        mode_next       = MODE_IDLE;
                        pos_next        = '0;
                        words_left_next = '0;
                    end
                    else
                    begin
                        words_left_next = words_left_reg - 31'd1;
                    end
                end
            end

            MODE_PIXEL:
            begin
                s_first_next.kind  = gcwp_pkg::KIND_PIXEL;
                s_first_next.x     = wrap_x(word[15:0]);
                s_first_next.y     = wrap_y(word[31:16]);
                s_first_next.pixel = pixel_reg;
                mode_next          = MODE_IDLE;
                pos_next           = '0;
                words_left_next    = '0;
            end

            MODE_READBACK:
            begin
                if (pos_cur >= POS_READBACK_END)
                begin
                    mode_next       = MODE_IDLE;
                    pos_next        = '0;
                    words_left_next = '0;
                end
                else
                begin
                    pos_next = pos_cur + 4'd1;
                end
            end

            default:
            begin
                mode_next = MODE_IDLE;
                pos_next  = '0;
            end
        endcase

        s_busy_next = mode_next != MODE_IDLE;
        s_tl_next   = corner_tl_next;
        s_br_next   = corner_br_next;

        // stage valid: a new item replaces a draining one
        if (accept)
        begin
            s_valid_next = 1'b1;
        end
        else if (drain)
        begin
            s_valid_next = 1'b0;
        end
        else
        begin
            s_valid_next = s_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            ptype_reg      <= '0;
            pos_reg        <= '0;
            words_left_reg <= '0;
            corner_tl_reg  <= '0;
            corner_br_reg  <= '0;
            s_valid_reg    <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            if (accept)
            begin
                mode_reg       <= mode_next;
                ptype_reg      <= ptype_next;
                pos_reg        <= pos_next;
                words_left_reg <= words_left_next;
                corner_tl_reg  <= corner_tl_next;
                corner_br_reg  <= corner_br_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            odd_reg      <= odd_next;
            width_reg    <= width_next;
            ox_reg       <= ox_next;
            oy_reg       <= oy_next;
            walk_reg     <= walk_next;
            pixel_reg    <= pixel_next;
            s_first_reg  <= s_first_next;
            s_second_reg <= s_second_next;
            s_two_reg    <= s_two_next;
            s_busy_reg   <= s_busy_next;
            s_tl_reg     <= s_tl_next;
            s_br_reg     <= s_br_next;
        end
    end

    // address generation into the result queue
    assign res_first  = make_res(s_first_reg, s_busy_reg, s_tl_reg, s_br_reg);
    assign res_second = make_res(s_second_reg, s_busy_reg, s_tl_reg, s_br_reg);

    assign fifo_ctl.push_first  = drain;
    assign fifo_ctl.push_second = drain && s_two_reg;
    assign fifo_ctl.pop         = out_valid && !out_stall;

    gcwp_result_fifo u_result_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (fifo_ctl),
        .data_first  (res_first),
        .data_second (res_second),
        .head        (head),
        .count       (fifo_count)
    );

    // output transfer
    assign out_valid    = fifo_count != '0;
    assign kind         = head.kind;
    assign vram_address = head.vram_address;
    assign vram_pixel   = head.vram_pixel;
    assign prim_type    = head.prim_type;
    assign word_index   = head.word_index;
    assign prim_word    = head.prim_word;
    assign last         = head.last;
    assign busy_res     = head.busy_res;
    assign area_left    = head.area_left;
    assign area_top     = head.area_top;
    assign area_right   = head.area_right;
    assign area_bottom  = head.area_bottom;

endmodule
